### hdl/wam_pkg.sv
// Shared types, constants and helpers for the weekly alarm matcher.
package wam_pkg;

  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned MAX_HOUR      = 23;
  localparam int unsigned MAX_MINUTE    = 59;

  // seconds of day fit in 17 bits even for out-of-range query times
  localparam int SEC_W  = 17;
  localparam int WAIT_W = 20;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [2:0] slot;
    logic [7:0] alarm_id;
    logic [6:0] day_bits;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic       enabled;
  } cmd_t;

  typedef struct packed {
    logic              write_rejected;
    logic              active_found;
    logic [7:0]        active_id;
    logic              next_found;
    logic [7:0]        next_id;
    logic [WAIT_W-1:0] seconds_to_next;
  } result_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_REJECT,
    KIND_IGNORE,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    logic [7:0]       alarm_id;
    logic [6:0]       mask;
    logic [4:0]       start_hour;
    logic [5:0]       start_minute;
    logic [4:0]       end_hour;
    logic [5:0]       end_minute;
    logic             enabled;
    logic [SEC_W-1:0] start_sec;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [2:0]       slot;
    entry_t           entry;
    logic [6:0]       q_day;
    logic [2:0]       q_day_mod;
    logic [4:0]       q_hour;
    logic [5:0]       q_minute;
    logic [SEC_W-1:0] q_now;
  } job_t;

  function automatic logic [SEC_W-1:0] seconds_of(input logic [4:0] h, input logic [5:0] m,
                                                  input logic [5:0] s);
    return SEC_W'(int'(h) * SEC_PER_HOUR + int'(m) * SEC_PER_MIN + int'(s));
  endfunction

  function automatic logic [WAIT_W-1:0] day_offset(input logic [2:0] d);
    case (d)
      3'd0:    return '0;
      3'd1:    return WAIT_W'(1 * SEC_PER_DAY);
      3'd2:    return WAIT_W'(2 * SEC_PER_DAY);
      3'd3:    return WAIT_W'(3 * SEC_PER_DAY);
      3'd4:    return WAIT_W'(4 * SEC_PER_DAY);
      3'd5:    return WAIT_W'(5 * SEC_PER_DAY);
      3'd6:    return WAIT_W'(6 * SEC_PER_DAY);
      default: return WAIT_W'(7 * SEC_PER_DAY);
    endcase
  endfunction

endpackage

### hdl/wam_front.sv
// Front end: classifies each command and precomputes times of day.
module wam_front #(
  parameter int ALARM_SLOTS = 8
) (
  input  wam_pkg::cmd_t cmd,
  output wam_pkg::job_t job
);

  logic       time_ok;
  logic       slot_ok;
  logic [14:0] prod;
  logic [4:0] quot;
  logic [7:0] rem;

  always_comb begin
    time_ok = (cmd.hour <= 5'(wam_pkg::MAX_HOUR)) && (cmd.minute <= 6'(wam_pkg::MAX_MINUTE)) &&
              (cmd.end_hour <= 5'(wam_pkg::MAX_HOUR)) &&
              (cmd.end_minute <= 6'(wam_pkg::MAX_MINUTE));
    slot_ok = 32'(cmd.slot) < 32'(ALARM_SLOTS);

    // weekday mod 7 by reciprocal multiply, one correction step
    prod = 15'(cmd.day_bits) * 15'd147;
    quot = prod[14:10];
    rem  = 8'(cmd.day_bits) - 8'(quot) * 8'(wam_pkg::DAYS_PER_WEEK);
    if (rem >= 8'(wam_pkg::DAYS_PER_WEEK)) begin
      rem = rem - 8'(wam_pkg::DAYS_PER_WEEK);
    end

    if (cmd.op == wam_pkg::OP_QUERY) begin
      job.kind = wam_pkg::KIND_QUERY;
    end else if (!time_ok) begin
      job.kind = wam_pkg::KIND_REJECT;
    end else if (!slot_ok) begin
      job.kind = wam_pkg::KIND_IGNORE;
    end else begin
      job.kind = wam_pkg::KIND_WRITE;
    end

    job.slot               = cmd.slot;
    job.entry.alarm_id     = cmd.alarm_id;
    job.entry.mask         = cmd.day_bits;
    job.entry.start_hour   = cmd.hour;
    job.entry.start_minute = cmd.minute;
    job.entry.end_hour     = cmd.end_hour;
    job.entry.end_minute   = cmd.end_minute;
    job.entry.enabled      = cmd.enabled;
    job.entry.start_sec    = wam_pkg::seconds_of(cmd.hour, cmd.minute, 6'd0);
    job.q_day              = cmd.day_bits;
    job.q_day_mod          = rem[2:0];
    job.q_hour             = cmd.hour;
    job.q_minute           = cmd.minute;
    job.q_now              = wam_pkg::seconds_of(cmd.hour, cmd.minute, cmd.second);
  end

endmodule

### hdl/wam_queue.sv
// Two-entry job queue between the front end and the back end.
module wam_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wam_pkg::job_t push_job,
  input  logic          pop,
  output wam_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);

  wam_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/wam_back.sv
// Back end: slot table, write execution and the per-slot query scan.
module wam_back #(
  parameter int ALARM_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  wam_pkg::job_t    head_job,
  output logic             pop,
  output logic             done,
  output wam_pkg::result_t result
);

  localparam int AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CW = $clog2(ALARM_SLOTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  wam_pkg::entry_t  mem [ALARM_SLOTS];
  logic [ALARM_SLOTS-1:0] valid;
  wam_pkg::entry_t  rd_data;
  logic             rd_vld;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [AW+2:0]    slot_ext;
  logic [CW-1:0]    issue_cnt;
  logic             scan_end;
  logic             done_next;

  // latched query
  logic [6:0]                 q_day;
  logic [2:0]                 q_day_mod;
  logic [4:0]                 q_hour;
  logic [5:0]                 q_minute;
  logic [wam_pkg::SEC_W-1:0]  q_now;

  // scan pipeline
  logic                       s1_valid;
  logic                       s2_valid;
  logic                       s2_has;
  logic                       s2_act;
  logic [7:0]                 s2_id;
  logic [wam_pkg::WAIT_W-1:0] s2_base;

  // running answers
  logic                       act;
  logic [7:0]                 act_id;
  logic                       nxt;
  logic [7:0]                 nxt_id;
  logic [wam_pkg::WAIT_W-1:0] best;

  logic                       live;
  logic [7:0]                 mask8;
  logic                       act_hit;
  logic [6:0]                 rot;
  logic [3:0]                 idx;
  logic [2:0]                 dsel;
  logic                       has;
  logic [wam_pkg::WAIT_W-1:0] base;
  logic [wam_pkg::WAIT_W-1:0] now_w;
  logic [wam_pkg::WAIT_W-1:0] wait_t;

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign mem_we   = pop && (head_job.kind == wam_pkg::KIND_WRITE);
  assign slot_ext = (AW + 3)'(head_job.slot);
  assign waddr    = slot_ext[AW-1:0];
  assign rd_en    = (state == ST_SCAN) && (issue_cnt < CW'(ALARM_SLOTS));
  assign rd_addr  = issue_cnt[AW-1:0];
  // drain the pipeline, then report
  assign scan_end  = (state == ST_SCAN) && !rd_en && !s1_valid && !s2_valid;
  assign done_next = (pop && (head_job.kind != wam_pkg::KIND_QUERY)) || scan_end;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= head_job.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // stage 1: active test and earliest start for one slot
  always_comb begin
    live    = rd_vld && rd_data.enabled;
    mask8   = {1'b0, rd_data.mask};
    act_hit = live && (q_day < 7'(wam_pkg::DAYS_PER_WEEK)) && mask8[q_day[2:0]] &&
              (q_hour >= rd_data.start_hour) && (q_hour <= rd_data.end_hour) &&
              (q_minute >= rd_data.start_minute) && (q_minute < rd_data.end_minute);
    idx = '0;
    for (int d = 0; d < 7; d++) begin
      idx = 4'(q_day_mod) + 4'(d);
      if (idx >= 4'(wam_pkg::DAYS_PER_WEEK)) begin
        idx = idx - 4'(wam_pkg::DAYS_PER_WEEK);
      end
      rot[d] = rd_data.mask[idx[2:0]];
    end
    // today's start already passed counts a full week ahead
    dsel = 3'd7;
    for (int d = 6; d >= 1; d--) begin
      if (rot[d]) begin
        dsel = 3'(d);
      end
    end
    if (rot[0] && (rd_data.start_sec >= q_now)) begin
      dsel = 3'd0;
    end
    base = wam_pkg::day_offset(dsel) + wam_pkg::WAIT_W'(rd_data.start_sec);
    has  = live && (rd_data.mask != 7'd0);
  end

  // stage 2: wait time, saturating at zero
  always_comb begin
    now_w  = wam_pkg::WAIT_W'(q_now);
    wait_t = (s2_base >= now_w) ? (s2_base - now_w) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      done      <= 1'b0;
      rd_vld    <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      issue_cnt <= '0;
      act       <= 1'b0;
      nxt       <= 1'b0;
    end else begin
      done     <= done_next;
      s1_valid <= rd_en;
      s2_valid <= s1_valid;
      s2_has   <= has;
      s2_act   <= act_hit;
      s2_id    <= rd_data.alarm_id;
      s2_base  <= base;
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head_job.kind == wam_pkg::KIND_QUERY) begin
              q_day     <= head_job.q_day;
              q_day_mod <= head_job.q_day_mod;
              q_hour    <= head_job.q_hour;
              q_minute  <= head_job.q_minute;
              q_now     <= head_job.q_now;
              act       <= 1'b0;
              act_id    <= '0;
              nxt       <= 1'b0;
              nxt_id    <= '0;
              best      <= '0;
              issue_cnt <= '0;
              state     <= ST_SCAN;
            end else begin
              if (head_job.kind == wam_pkg::KIND_WRITE) begin
                valid[waddr] <= 1'b1;
              end
              result.write_rejected  <= (head_job.kind == wam_pkg::KIND_REJECT);
              result.active_found    <= 1'b0;
              result.active_id       <= '0;
              result.next_found      <= 1'b0;
              result.next_id         <= '0;
              result.seconds_to_next <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          if (s2_valid) begin
            if (s2_act && !act) begin
              act    <= 1'b1;
              act_id <= s2_id;
            end
            if (s2_has && (!nxt || (wait_t < best))) begin
              nxt    <= 1'b1;
              nxt_id <= s2_id;
              best   <= wait_t;
            end
          end
          if (scan_end) begin
            result.write_rejected  <= 1'b0;
            result.active_found    <= act;
            result.active_id       <= act_id;
            result.next_found      <= nxt;
            result.next_id         <= nxt_id;
            result.seconds_to_next <= best;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/weekly_alarm_matcher.sv
// Top level of the weekly alarm matcher: front end, job queue and back end.
//
//   channel   ports              beat taken when
//   command   start, cmd, busy   start && !busy at the rising edge
//   result    done, result       done high, one cycle, no back-pressure
//
// A write beat is queued, popped once the back end is idle, and reported by the
// registered done. A query scans the slot table one slot per cycle through a
// two-stage pipeline behind the table read port.
// The two-entry queue lets up to two commands wait while the back end works;
// busy is high while it is full. Synchronous reset clears the valid bit of every
// slot at once, so commands are taken from the first cycle after reset.
module weekly_alarm_matcher #(
  parameter int ALARM_SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  wam_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output wam_pkg::result_t result
);

  wam_pkg::job_t front_job;
  wam_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  assign busy = q_full;
  assign push = start && !q_full;

  wam_front #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_front (
    .cmd(cmd),
    .job(front_job)
  );

  wam_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(front_job),
    .pop(pop),
    .head_job(head_job),
    .empty(q_empty),
    .full(q_full)
  );

  wam_back #(
    .ALARM_SLOTS(ALARM_SLOTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .head_job(head_job),
    .pop(pop),
    .done(done),
    .result(result)
  );

endmodule
